// File: hw/rtl/cigar_site_support_counter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the site support counter
// Property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CIGAR_SITE_SUPPORT_COUNTER_TOP_MACROS_SVH
`define CIGAR_SITE_SUPPORT_COUNTER_TOP_MACROS_SVH

// same-cycle implication
`define CSSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cssc assertion failed");

// next-cycle implication
`define CSSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cssc assertion failed");

`endif

// File: hw/rtl/cssc_pkg.sv
// ----------------------------------------------------------------------------
// cssc_pkg
// Types, codes and sizes shared by the site support counter modules.
// ----------------------------------------------------------------------------
package cssc_pkg;

  localparam int SEQ_BYTES   = 512;
  localparam int SEQ_AW      = $clog2(SEQ_BYTES);
  localparam int QRY_W       = SEQ_AW + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_W       = 31;
  localparam int CFG_IDX_W   = 3;
  localparam int CNT_W       = 32;

  typedef enum logic [0:0] {
    OPN_SEQ   = 1'b0,
    OPN_CIGAR = 1'b1
  } opn_t;

  typedef enum logic [3:0] {
    CIG_M = 4'd0,
    CIG_I = 4'd1,
    CIG_D = 4'd2,
    CIG_N = 4'd3,
    CIG_S = 4'd4,
    CIG_H = 4'd5,
    CIG_P = 4'd6,
    CIG_E = 4'd7,
    CIG_X = 4'd8
  } cigar_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_MODE = 3'd0,
    CFG_TARGET_POS  = 3'd1,
    CFG_TARGET_END  = 3'd2,
    CFG_DEL_LEN     = 3'd3,
    CFG_ALT_BASE    = 3'd4,
    CFG_REF_LEN     = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_WRITE = 3'd1,
    EV_REF   = 3'd2,
    EV_ALT   = 3'd3,
    EV_LOOK  = 3'd4
  } ev_kind_t;

  typedef struct packed {
    logic        detect_mode;
    logic [30:0] target_position;
    logic [30:0] target_end;
    logic [27:0] deletion_length;
    logic [3:0]  alt_base;
    logic [30:0] reference_length;
  } cfg_t;

  typedef struct packed {
    logic        operation;
    logic [8:0]  seq_offset;
    logic [7:0]  seq_byte;
    logic [30:0] read_position;
    logic [3:0]  cigar_code;
    logic [27:0] cigar_length;
    logic        first_op;
    logic        last_op;
  } req_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [SEQ_AW-1:0] addr;
    logic [7:0]        data;
    logic              nib_lo;
    logic              last;
  } event_t;

endpackage

// File: hw/rtl/cssc_ram.sv
// ----------------------------------------------------------------------------
// cssc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/cssc_front.sv
// ----------------------------------------------------------------------------
// cssc_front
// CIGAR walker: tracks reference and query cursors and classifies each
// request into a queue event for the counting side.
// ----------------------------------------------------------------------------
module cssc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  cssc_pkg::cfg_t   cfg,
  input  logic             req_valid,
  input  cssc_pkg::req_t   req,
  input  logic             q_full,
  output logic             req_stall,
  output logic             push,
  output cssc_pkg::event_t push_ev
);

  localparam int QW = cssc_pkg::QRY_W;

  logic [31:0]   ref_cur_r, ref_cur_nxt;
  logic [QW-1:0] qry_r, qry_nxt;
  logic          anchor_r, anchor_nxt;
  logic          fin_r, fin_nxt;

  logic          accept;
  logic          is_cigar;
  logic [31:0]   pos;
  logic [QW-1:0] qc;
  logic          anc;
  logic          fin;
  logic [32:0]   sum_len;
  logic [32:0]   sum_dl;
  logic          pos_le_t;
  logic          t_lt_end;
  logic          t_lt_rl;
  logic          over;
  logic          pos_lt_rl;
  logic [31:0]   stop;
  logic [QW-1:0] run_q;
  logic          run_ge_dl;
  logic          stop_gt_te;
  logic [QW-1:0] diff;
  logic [QW-1:0] q_look;
  cssc_pkg::ev_kind_t kind;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign is_cigar  = (cssc_pkg::opn_t'(req.operation) == cssc_pkg::OPN_CIGAR);

  always_comb begin
    pos = req.first_op ? {1'b0, req.read_position} : ref_cur_r;
    qc  = req.first_op ? '0 : qry_r;
    anc = req.first_op ? 1'b0 : anchor_r;
    fin = req.first_op ? 1'b0 : fin_r;

    sum_len    = {1'b0, pos} + {5'b0, req.cigar_length};
    sum_dl     = {1'b0, pos} + {5'b0, cfg.deletion_length};
    pos_le_t   = pos <= {1'b0, cfg.target_position};
    t_lt_end   = {2'b0, cfg.target_position} < sum_len;
    t_lt_rl    = cfg.target_position < cfg.reference_length;
    over       = sum_len > {2'b0, cfg.reference_length};
    pos_lt_rl  = pos < {1'b0, cfg.reference_length};
    stop       = over ? (pos_lt_rl ? {1'b0, cfg.reference_length} : pos) : sum_len[31:0];
    run_q      = over ? (pos_lt_rl ? (cfg.reference_length[QW-1:0] - pos[QW-1:0]) : '0)
                      : req.cigar_length[QW-1:0];
    run_ge_dl  = (req.cigar_length >= cfg.deletion_length) &&
                 ((cfg.deletion_length == '0) || (sum_dl <= {2'b0, cfg.reference_length}));
    stop_gt_te = (sum_len > {2'b0, cfg.target_end}) &&
                 ((pos > {1'b0, cfg.target_end}) ||
                  (cfg.reference_length > cfg.target_end));
    diff       = cfg.target_position[QW-1:0] - pos[QW-1:0];
    q_look     = qc + diff;

    ref_cur_nxt = pos;
    qry_nxt     = qc;
    anchor_nxt  = anc;
    fin_nxt     = fin;
    kind        = cssc_pkg::EV_NONE;

    if (!fin) begin
      case (cssc_pkg::cigar_op_t'(req.cigar_code))
        cssc_pkg::CIG_M: begin
          if (!cfg.detect_mode && pos_le_t && t_lt_end && t_lt_rl) begin
            kind    = cssc_pkg::EV_LOOK;
            qry_nxt = q_look;
            fin_nxt = 1'b1;
          end else begin
            if (cfg.detect_mode) begin
              if (pos_le_t && run_ge_dl) begin
                kind = cssc_pkg::EV_REF;
              end else if (pos_le_t) begin
                anchor_nxt = 1'b1;
              end else if (stop_gt_te && anc) begin
                kind = cssc_pkg::EV_REF;
              end
            end
            ref_cur_nxt = stop;
            qry_nxt     = qc + run_q;
          end
        end
        cssc_pkg::CIG_I, cssc_pkg::CIG_S: begin
          qry_nxt = qc + req.cigar_length[QW-1:0];
        end
        cssc_pkg::CIG_D: begin
          if (cfg.detect_mode && (pos == {1'b0, cfg.target_position}) &&
              (req.cigar_length == cfg.deletion_length)) begin
            kind = cssc_pkg::EV_ALT;
          end
          ref_cur_nxt = pos + {4'b0, req.cigar_length};
        end
        cssc_pkg::CIG_N: begin
          if (!cfg.detect_mode && pos_le_t && t_lt_end) begin
            kind    = cssc_pkg::EV_REF;
            fin_nxt = 1'b1;
          end else begin
            ref_cur_nxt = pos + {4'b0, req.cigar_length};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_cur_r <= '0;
      qry_r     <= '0;
      anchor_r  <= 1'b0;
      fin_r     <= 1'b0;
    end else if (accept && is_cigar) begin
      ref_cur_r <= ref_cur_nxt;
      qry_r     <= qry_nxt;
      anchor_r  <= anchor_nxt;
      fin_r     <= fin_nxt;
    end
  end

  always_comb begin
    push           = accept;
    push_ev.kind   = is_cigar ? kind : cssc_pkg::EV_WRITE;
    push_ev.addr   = is_cigar ? q_look[QW-1:1] : req.seq_offset;
    push_ev.data   = req.seq_byte;
    push_ev.nib_lo = q_look[0];
    push_ev.last   = is_cigar && req.last_op;
  end

endmodule

// File: hw/rtl/cssc_fifo.sv
// ----------------------------------------------------------------------------
// cssc_fifo
// Short event queue between the walker and the counting side.
// ----------------------------------------------------------------------------
`include "cigar_site_support_counter_top_macros.svh"

module cssc_fifo #(
  parameter int DEPTH = cssc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cssc_pkg::event_t push_ev,
  output logic             full,
  output logic             head_valid,
  output cssc_pkg::event_t head_ev,
  input  logic             pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cssc_pkg::event_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_ev    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ev;
    end
  end

  `CSSC_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !full)
  `CSSC_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, head_valid)
  `CSSC_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - 1'b1)
  `CSSC_ASSERT_NEXT(a_push_fills, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

// File: hw/rtl/cssc_back.sv
// ----------------------------------------------------------------------------
// cssc_back
// Counting side: performs store writes and base lookups, keeps the
// saturating support counts and holds the result register.
// ----------------------------------------------------------------------------
module cssc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [3:0]                  alt_base,
  input  logic                        head_valid,
  input  cssc_pkg::event_t            head_ev,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cssc_pkg::CNT_W-1:0]  out_ref_count,
  output logic [cssc_pkg::CNT_W-1:0]  out_alt_count
);

  localparam int CW = cssc_pkg::CNT_W;

  logic               s2_v_r, s2_v_nxt;
  cssc_pkg::ev_kind_t s2_kind_r;
  logic               s2_nib_r;
  logic               s2_last_r;
  logic               s2_ready;
  logic               s2_fire;
  logic [7:0]         rdata;
  logic [3:0]         base;
  logic               inc_ref;
  logic               inc_alt;
  logic [CW-1:0]      ref_cnt_r, ref_cnt_nxt;
  logic [CW-1:0]      alt_cnt_r, alt_cnt_nxt;
  logic               out_v_r, out_v_nxt;
  logic [CW-1:0]      out_ref_r;
  logic [CW-1:0]      out_alt_r;
  logic               load_out;

  assign s2_ready = !s2_v_r || !(s2_last_r && out_v_r && out_stall);
  assign pop      = head_valid && s2_ready;
  assign s2_fire  = s2_v_r && s2_ready;

  cssc_ram #(
    .WIDTH (8),
    .DEPTH (cssc_pkg::SEQ_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (pop && (head_ev.kind == cssc_pkg::EV_WRITE)),
    .waddr (head_ev.addr),
    .wdata (head_ev.data),
    .re    (pop && (head_ev.kind == cssc_pkg::EV_LOOK)),
    .raddr (head_ev.addr),
    .rdata (rdata)
  );

  always_comb begin
    base    = s2_nib_r ? rdata[3:0] : rdata[7:4];
    inc_ref = (s2_kind_r == cssc_pkg::EV_REF) ||
              ((s2_kind_r == cssc_pkg::EV_LOOK) && (base != alt_base));
    inc_alt = (s2_kind_r == cssc_pkg::EV_ALT) ||
              ((s2_kind_r == cssc_pkg::EV_LOOK) && (base == alt_base));

    ref_cnt_nxt = ref_cnt_r;
    alt_cnt_nxt = alt_cnt_r;
    if (s2_fire && inc_ref && (ref_cnt_r != '1)) begin
      ref_cnt_nxt = ref_cnt_r + 1'b1;
    end
    if (s2_fire && inc_alt && (alt_cnt_r != '1)) begin
      alt_cnt_nxt = alt_cnt_r + 1'b1;
    end

    load_out = s2_fire && s2_last_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
    end else if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end

    if (pop) begin
      s2_v_nxt = 1'b1;
    end else if (s2_fire) begin
      s2_v_nxt = 1'b0;
    end else begin
      s2_v_nxt = s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r    <= 1'b0;
      ref_cnt_r <= '0;
      alt_cnt_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      s2_v_r    <= s2_v_nxt;
      ref_cnt_r <= ref_cnt_nxt;
      alt_cnt_r <= alt_cnt_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_kind_r <= head_ev.kind;
      s2_nib_r  <= head_ev.nib_lo;
      s2_last_r <= head_ev.last;
    end
    if (load_out) begin
      out_ref_r <= ref_cnt_nxt;
      out_alt_r <= alt_cnt_nxt;
    end
  end

  assign out_valid     = out_v_r;
  assign out_ref_count = out_ref_r;
  assign out_alt_count = out_alt_r;

endmodule

// File: hw/rtl/cigar_site_support_counter_top.sv
// A read's result goes via the queue, stage-two and result registers to out_valid.
// Throughput: one request per cycle while in_stall is low; accepts update both cursors.
// The event queue absorbs output stalls; in_stall rises only when it fills.
// Reset: synchronous active low; clears cursors, counts, queue and configuration.
// The sequence store is not cleared and reads as undefined until written.
// ----------------------------------------------------------------------------
// cigar_site_support_counter_top
// Counts reads supporting the reference or an alternative at one target site.
// ----------------------------------------------------------------------------
module cigar_site_support_counter_top #(
  parameter int QUEUE_DEPTH = cssc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cssc_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [8:0]                      in_seq_offset,
  input  logic [7:0]                      in_seq_byte,
  input  logic [30:0]                     in_read_position,
  input  logic [3:0]                      in_cigar_code,
  input  logic [27:0]                     in_cigar_length,
  input  logic                            in_first_op,
  input  logic                            in_last_op,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cssc_pkg::CNT_W-1:0]      out_ref_count,
  output logic [cssc_pkg::CNT_W-1:0]      out_alt_count
);

  cssc_pkg::cfg_t   cfg_r;
  cssc_pkg::req_t   req;
  cssc_pkg::event_t push_ev;
  cssc_pkg::event_t head_ev;
  logic             push;
  logic             q_full;
  logic             head_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cssc_pkg::cfg_idx_t'(cfg_index))
        cssc_pkg::CFG_DETECT_MODE: cfg_r.detect_mode      <= cfg_wdata[0];
        cssc_pkg::CFG_TARGET_POS:  cfg_r.target_position  <= cfg_wdata;
        cssc_pkg::CFG_TARGET_END:  cfg_r.target_end       <= cfg_wdata;
        cssc_pkg::CFG_DEL_LEN:     cfg_r.deletion_length  <= cfg_wdata[27:0];
        cssc_pkg::CFG_ALT_BASE:    cfg_r.alt_base         <= cfg_wdata[3:0];
        cssc_pkg::CFG_REF_LEN:     cfg_r.reference_length <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    req.operation     = in_operation;
    req.seq_offset    = in_seq_offset;
    req.seq_byte      = in_seq_byte;
    req.read_position = in_read_position;
    req.cigar_code    = in_cigar_code;
    req.cigar_length  = in_cigar_length;
    req.first_op      = in_first_op;
    req.last_op       = in_last_op;
  end

  cssc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .req_valid (in_valid),
    .req       (req),
    .q_full    (q_full),
    .req_stall (in_stall),
    .push      (push),
    .push_ev   (push_ev)
  );

  cssc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ev    (push_ev),
    .full       (q_full),
    .head_valid (head_valid),
    .head_ev    (head_ev),
    .pop        (pop)
  );

  cssc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .alt_base      (cfg_r.alt_base),
    .head_valid    (head_valid),
    .head_ev       (head_ev),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ref_count (out_ref_count),
    .out_alt_count (out_alt_count)
  );

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: site support counter testbench
// Drives sequence writes and CIGAR walks into the counter under several
// register settings and handshake pacings, and checks every returned count
// pair against an in-bench prediction of the read walk or a directed value.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int BLOCK_ITEMS = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int CFG_DW = cssc_pkg::CFG_W;

  typedef struct packed {
    logic [31:0] refc;
    logic [31:0] altc;
  } count_pair_t;

  typedef struct {
    logic [31:0] rcur;
    logic [31:0] qcur;
    bit          anchor;
    bit          done;
    logic [31:0] refc;
    logic [31:0] altc;
  } walk_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [27:0] len;
  } cigar_op_rec_t;

  typedef struct {
    bit             is_cfg;
    cssc_pkg::cfg_t cfg;
    cssc_pkg::req_t rq;
    bit             typed;
    count_pair_t    tv;
  } stim_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [cssc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cssc_pkg::CFG_W-1:0]     cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_operation;
  logic [8:0]                     in_seq_offset;
  logic [7:0]                     in_seq_byte;
  logic [30:0]                    in_read_position;
  logic [3:0]                     in_cigar_code;
  logic [27:0]                    in_cigar_length;
  logic                           in_first_op;
  logic                           in_last_op;
  logic                           out_valid;
  logic                           out_stall;
  logic [cssc_pkg::CNT_W-1:0]     out_ref_count;
  logic [cssc_pkg::CNT_W-1:0]     out_alt_count;

  cigar_site_support_counter_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_seq_offset    (in_seq_offset),
    .in_seq_byte      (in_seq_byte),
    .in_read_position (in_read_position),
    .in_cigar_code    (in_cigar_code),
    .in_cigar_length  (in_cigar_length),
    .in_first_op      (in_first_op),
    .in_last_op       (in_last_op),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ref_count    (out_ref_count),
    .out_alt_count    (out_alt_count)
  );

  cssc_pkg::cfg_t cfg_now;
  walk_t          read_walk;
  logic [7:0]     seq_img [cssc_pkg::SEQ_BYTES];
  bit             seq_ok [cssc_pkg::SEQ_BYTES];
  count_pair_t    expected_counts[$];
  count_pair_t    want_pair;
  stim_row_t      stim_rows[$];

  int snd_idle;
  int rcv_idle;
  int mismatches;
  int requests_sent;
  int reads_sent;
  int results_seen;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_counts.size() == 0) begin
        report_mismatch("count pair with none pending, ref_count", out_ref_count, '0);
      end else begin
        want_pair = expected_counts.pop_front();
        if (out_ref_count !== want_pair.refc)
          report_mismatch("ref_count", out_ref_count, want_pair.refc);
        if (out_alt_count !== want_pair.altc)
          report_mismatch("alt_count", out_alt_count, want_pair.altc);
      end
    end
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Walk one CIGAR request; rd/ra report a sequence store lookup.
  function automatic void walk_cigar(inout walk_t w, input cssc_pkg::req_t r,
                                     output bit rd, output logic [8:0] ra);
    logic [32:0] pos;
    logic [32:0] tgt;
    logic [32:0] lim;
    logic [32:0] run;
    logic [32:0] stop;
    logic [31:0] q;
    logic [7:0]  b;
    logic [3:0]  base;
    rd = 1'b0;
    ra = '0;
    if (r.first_op) begin
      w.rcur = {1'b0, r.read_position};
      w.qcur = '0;
      w.anchor = 1'b0;
      w.done = 1'b0;
    end
    if (w.done) return;
    pos = {1'b0, w.rcur};
    tgt = {2'b0, cfg_now.target_position};
    lim = {2'b0, cfg_now.reference_length};
    case (r.cigar_code)
      cssc_pkg::CIG_M: begin
        run = {5'b0, r.cigar_length};
        if (pos + run > lim) run = (pos < lim) ? lim - pos : '0;
        stop = pos + run;
        if (!cfg_now.detect_mode && pos <= tgt && tgt < stop) begin
          q = w.qcur + 32'(tgt - pos);
          rd = 1'b1;
          ra = q[9:1];
          b = seq_img[ra];
          base = q[0] ? b[3:0] : b[7:4];
          w.qcur = q;
          if (base == cfg_now.alt_base) w.altc = bump(w.altc);
          else w.refc = bump(w.refc);
          w.done = 1'b1;
          return;
        end
        if (cfg_now.detect_mode) begin
          if (pos <= tgt && run >= {5'b0, cfg_now.deletion_length}) w.refc = bump(w.refc);
          else if (pos <= tgt) w.anchor = 1'b1;
          else if (stop > {2'b0, cfg_now.target_end} && w.anchor) w.refc = bump(w.refc);
        end
        w.rcur += run[31:0];
        w.qcur += run[31:0];
      end
      cssc_pkg::CIG_I, cssc_pkg::CIG_S: w.qcur += {4'b0, r.cigar_length};
      cssc_pkg::CIG_D: begin
        if (cfg_now.detect_mode && pos == tgt && r.cigar_length == cfg_now.deletion_length)
          w.altc = bump(w.altc);
        w.rcur += {4'b0, r.cigar_length};
      end
      cssc_pkg::CIG_N: begin
        if (!cfg_now.detect_mode && pos <= tgt && tgt < pos + {5'b0, r.cigar_length}) begin
          w.refc = bump(w.refc);
          w.done = 1'b1;
          return;
        end
        w.rcur += {4'b0, r.cigar_length};
      end
      default: ;
    endcase
  endfunction

  function automatic void note_seq(input cssc_pkg::req_t r);
    seq_img[r.seq_offset] = r.seq_byte;
    seq_ok[r.seq_offset] = 1'b1;
  endfunction

  function automatic cssc_pkg::req_t rand_req();
    cssc_pkg::req_t r;
    r.operation = 1'($urandom);
    r.seq_offset = 9'($urandom);
    r.seq_byte = 8'($urandom);
    r.read_position = 31'($urandom);
    r.cigar_code = 4'($urandom);
    r.cigar_length = 28'($urandom);
    r.first_op = 1'($urandom);
    r.last_op = 1'($urandom);
    return r;
  endfunction

  function automatic cssc_pkg::req_t seq_req(input logic [8:0] off, input logic [7:0] data);
    cssc_pkg::req_t r;
    r = rand_req();
    r.operation = cssc_pkg::OPN_SEQ;
    r.seq_offset = off;
    r.seq_byte = data;
    return r;
  endfunction

  function automatic cssc_pkg::req_t cg(input logic [3:0] code, input logic [27:0] len,
                                        input logic [30:0] pos, input logic fst,
                                        input logic lst);
    cssc_pkg::req_t r;
    r = '0;
    r.operation = cssc_pkg::OPN_CIGAR;
    r.cigar_code = code;
    r.cigar_length = len;
    r.read_position = pos;
    r.first_op = fst;
    r.last_op = lst;
    return r;
  endfunction

  function automatic cssc_pkg::req_t sq(input logic [8:0] off, input logic [7:0] data);
    cssc_pkg::req_t r;
    r = '0;
    r.operation = cssc_pkg::OPN_SEQ;
    r.seq_offset = off;
    r.seq_byte = data;
    return r;
  endfunction

  task automatic drive_req(input cssc_pkg::req_t r);
    bit took;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= r.operation;
    in_seq_offset    <= r.seq_offset;
    in_seq_byte      <= r.seq_byte;
    in_read_position <= r.read_position;
    in_cigar_code    <= r.cigar_code;
    in_cigar_length  <= r.cigar_length;
    in_first_op      <= r.first_op;
    in_last_op       <= r.last_op;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    requests_sent++;
  endtask

  // Predict, then send; fill any store byte the walk would look up unwritten.
  task automatic send_req(input cssc_pkg::req_t r, input bit typed, input count_pair_t tv);
    walk_t          probe;
    bit             rd;
    logic [8:0]     ra;
    cssc_pkg::req_t fill;
    count_pair_t    got;
    if (r.operation == cssc_pkg::OPN_CIGAR) begin
      probe = read_walk;
      walk_cigar(probe, r, rd, ra);
      if (rd && !seq_ok[ra]) begin
        fill = seq_req(ra, 8'($urandom));
        note_seq(fill);
        drive_req(fill);
      end
      walk_cigar(read_walk, r, rd, ra);
      if (r.last_op) begin
        got.refc = read_walk.refc;
        got.altc = read_walk.altc;
        expected_counts.push_back(typed ? tv : got);
      end
    end else begin
      note_seq(r);
    end
    drive_req(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cssc_pkg::cfg_idx_t idx, input logic [CFG_DW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic program_cfg(input cssc_pkg::cfg_t c);
    write_reg(cssc_pkg::CFG_DETECT_MODE, CFG_DW'(c.detect_mode));
    write_reg(cssc_pkg::CFG_TARGET_POS, CFG_DW'(c.target_position));
    write_reg(cssc_pkg::CFG_TARGET_END, CFG_DW'(c.target_end));
    write_reg(cssc_pkg::CFG_DEL_LEN, CFG_DW'(c.deletion_length));
    write_reg(cssc_pkg::CFG_ALT_BASE, CFG_DW'(c.alt_base));
    write_reg(cssc_pkg::CFG_REF_LEN, CFG_DW'(c.reference_length));
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  function automatic logic [30:0] clamp31(input logic [30:0] a, input int unsigned n);
    logic [31:0] t;
    t = {1'b0, a} + n;
    return t[31] ? 31'h7FFF_FFFF : t[30:0];
  endfunction

  function automatic cssc_pkg::cfg_t pick_cfg(input int blk);
    cssc_pkg::cfg_t c;
    c.detect_mode = blk[0];
    case (blk)
      2:       c.target_position = 31'h7FFF_FFFF;
      3:       c.target_position = '0;
      10:      c.target_position = 31'($urandom);
      default: c.target_position = 31'($urandom_range(0, 5000));
    endcase
    c.target_end = clamp31(c.target_position, $urandom_range(0, 60));
    case (blk)
      6:       c.deletion_length = '0;
      7:       c.deletion_length = 28'hFFF_FFFF;
      11:      c.deletion_length = 28'($urandom);
      default: c.deletion_length = 28'($urandom_range(1, 8));
    endcase
    case (blk)
      8:       c.alt_base = 4'h0;
      9:       c.alt_base = 4'hF;
      default: c.alt_base = 4'($urandom);
    endcase
    case (blk)
      4:       c.reference_length = '0;
      5:       c.reference_length = 31'h7FFF_FFFF;
      1:       c.reference_length = 31'($urandom);
      default: c.reference_length = clamp31(c.target_position, $urandom_range(0, 200));
    endcase
    return c;
  endfunction

  function automatic logic [3:0] pick_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return cssc_pkg::CIG_M;
    if (r < 55) return cssc_pkg::CIG_I;
    if (r < 68) return cssc_pkg::CIG_D;
    if (r < 76) return cssc_pkg::CIG_N;
    if (r < 86) return cssc_pkg::CIG_S;
    if (r < 94) return 4'($urandom_range(int'(cssc_pkg::CIG_H), int'(cssc_pkg::CIG_X)));
    return 4'($urandom_range(int'(cssc_pkg::CIG_X) + 1, 15));
  endfunction

  function automatic logic [27:0] pick_len(input logic [3:0] code);
    int r;
    if (code == cssc_pkg::CIG_D && $urandom_range(0, 99) < 40) return cfg_now.deletion_length;
    r = $urandom_range(0, 99);
    if (r < 85) return 28'($urandom_range(1, 30));
    if (r < 92) return '0;
    if (r < 96) return 28'hFFF_FFFF;
    return 28'($urandom);
  endfunction

  task automatic send_read();
    cigar_op_rec_t  plan[$];
    cigar_op_rec_t  rec;
    cssc_pkg::req_t r;
    logic [30:0]    tp;
    logic [30:0]    start;
    int             lead;
    int             nops;
    bit             noisy;
    repeat ($urandom_range(0, 3)) send_req(seq_req(9'($urandom), 8'($urandom)), 1'b0, '0);
    noisy = ($urandom_range(0, 99) < 15);
    tp = cfg_now.target_position;
    lead = $urandom_range(0, 40);
    start = (tp > 31'(lead)) ? tp - 31'(lead) : '0;
    if ($urandom_range(0, 9) == 0) start = 31'($urandom);
    if (!noisy && $urandom_range(0, 99) < 40) begin
      rec.code = cssc_pkg::CIG_M;
      rec.len = 28'(tp - start);
      plan.push_back(rec);
      if (cfg_now.detect_mode) begin
        rec.code = cssc_pkg::CIG_D;
        rec.len = cfg_now.deletion_length;
      end else begin
        rec.code = pick_code();
        rec.len = pick_len(rec.code);
      end
      plan.push_back(rec);
      rec.code = cssc_pkg::CIG_M;
      rec.len = pick_len(cssc_pkg::CIG_M);
      plan.push_back(rec);
    end else begin
      nops = $urandom_range(1, 6);
      repeat (nops) begin
        rec.code = pick_code();
        rec.len = pick_len(rec.code);
        plan.push_back(rec);
      end
    end
    foreach (plan[i]) begin
      r = rand_req();
      r.operation = cssc_pkg::OPN_CIGAR;
      r.cigar_code = plan[i].code;
      r.cigar_length = plan[i].len;
      if (!noisy) begin
        r.first_op = (i == 0);
        r.last_op = (i == plan.size() - 1);
        r.read_position = start;
      end
      send_req(r, 1'b0, '0);
    end
    reads_sent++;
  endtask

  task automatic add_cfg(input cssc_pkg::cfg_t c);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg = c;
    stim_rows.push_back(row);
  endtask

  task automatic add_req(input cssc_pkg::req_t r);
    stim_row_t row;
    row = '{default: '0};
    row.rq = r;
    stim_rows.push_back(row);
  endtask

  task automatic add_req_typed(input cssc_pkg::req_t r, input logic [31:0] refc,
                               input logic [31:0] altc);
    stim_row_t row;
    row = '{default: '0};
    row.rq = r;
    row.typed = 1'b1;
    row.tv.refc = refc;
    row.tv.altc = altc;
    stim_rows.push_back(row);
  endtask

  task automatic build_directed();
    // ignored code with no read start, reset registers
    add_req_typed(cg(cssc_pkg::CIG_H, 28'd5, 31'd0, 1'b0, 1'b1), 32'd0, 32'd0);
    add_cfg(cssc_pkg::cfg_t'{1'b0, 31'd10, 31'd20, 28'd0, 4'hA, 31'd1000});
    add_req(sq(9'd5, 8'hA3));
    add_req_typed(cg(cssc_pkg::CIG_M, 28'd100, 31'd0, 1'b1, 1'b1), 32'd0, 32'd1);
    add_req(sq(9'd3, 8'h12));
    add_req(cg(cssc_pkg::CIG_S, 28'd1, 31'd5, 1'b1, 1'b0));
    add_req(cg(cssc_pkg::CIG_M, 28'd100, 31'd0, 1'b0, 1'b1));
    add_req(cg(cssc_pkg::CIG_N, 28'd20, 31'd0, 1'b1, 1'b1));
    add_req(cg(cssc_pkg::CIG_I, 28'd3, 31'd8, 1'b1, 1'b0));
    add_req(cg(cssc_pkg::CIG_D, 28'd1, 31'd0, 1'b0, 1'b0));
    add_req(cg(cssc_pkg::CIG_H, 28'd2, 31'd0, 1'b0, 1'b0));
    add_req(cg(cssc_pkg::CIG_P, 28'd2, 31'd0, 1'b0, 1'b0));
    add_req(cg(cssc_pkg::CIG_E, 28'd2, 31'd0, 1'b0, 1'b0));
    add_req(cg(cssc_pkg::CIG_X, 28'd2, 31'd0, 1'b0, 1'b0));
    add_req(cg(4'hF, 28'd7, 31'd0, 1'b0, 1'b0));
    add_req(cg(cssc_pkg::CIG_M, 28'd5, 31'd0, 1'b0, 1'b0));
    // read already decided: still answers with counts
    add_req(cg(cssc_pkg::CIG_M, 28'd5, 31'd0, 1'b0, 1'b1));
    add_req(sq(9'd511, 8'hFF));
    add_req(sq(9'd0, 8'h00));
    add_req(cg(cssc_pkg::CIG_M, 28'hFFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1));
    add_req(cg(cssc_pkg::CIG_M, 28'hFFF_FFFF, 31'd995, 1'b1, 1'b1));
    add_cfg(cssc_pkg::cfg_t'{1'b1, 31'd50, 31'd60, 28'd3, 4'h0, 31'h7FFF_FFFF});
    add_req(cg(cssc_pkg::CIG_M, 28'd2, 31'd48, 1'b1, 1'b0));
    add_req(cg(cssc_pkg::CIG_D, 28'd3, 31'd0, 1'b0, 1'b0));
    add_req(cg(cssc_pkg::CIG_M, 28'd20, 31'd0, 1'b0, 1'b1));
    add_req(cg(cssc_pkg::CIG_M, 28'd60, 31'd0, 1'b1, 1'b1));
  endtask

  initial begin
    int mark;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= cssc_pkg::CFG_DETECT_MODE;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_operation     <= cssc_pkg::OPN_SEQ;
    in_seq_offset    <= '0;
    in_seq_byte      <= '0;
    in_read_position <= '0;
    in_cigar_code    <= cssc_pkg::CIG_M;
    in_cigar_length  <= '0;
    in_first_op      <= 1'b0;
    in_last_op       <= 1'b0;
    out_stall        <= 1'b0;
    cycles = 0;
    mismatches = 0;
    requests_sent = 0;
    reads_sent = 0;
    results_seen = 0;
    cfg_now = '0;
    read_walk = '{default: '0};
    foreach (seq_ok[i]) seq_ok[i] = 1'b0;
    snd_idle = 36;
    rcv_idle = 79;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain();
        program_cfg(stim_rows[i].cfg);
      end else begin
        send_req(stim_rows[i].rq, stim_rows[i].typed, stim_rows[i].tv);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin snd_idle = 36; rcv_idle = 79; end
        1:       begin snd_idle = 79; rcv_idle = 36; end
        default: begin snd_idle = 0;  rcv_idle = 0;  end
      endcase
      for (int k = 0; k < 4; k++) begin
        drain();
        program_cfg(pick_cfg(ph * 4 + k));
        mark = requests_sent;
        while (requests_sent - mark < BLOCK_ITEMS) begin
          send_read();
          // hold off until every pending count pair is back
          if ($urandom_range(0, 59) == 0) drain();
        end
      end
    end
    drain();

    $display("Covered %0d requests in %0d reads, %0d count pairs checked,", requests_sent,
             reads_sent, results_seen);
    $display("across both detect modes, register extremes and three pacing profiles.");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
